/* sv/nns_pkg.sv */
`timescale 1ns / 1ps
package nns_pkg;

  localparam int SIZE_W  = 9;
  localparam int COORD_W = 16;
  localparam int PIXEL_W = 32;
  localparam int FACT_W  = 16;
  localparam int FRAC_W  = 8;
  localparam int DVD_W   = COORD_W + FRAC_W;
  localparam int PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_FACTOR = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // per-beat control and payload that rides alongside the dividers
  typedef struct packed {
    logic                 valid;
    logic                 op;
    logic                 bad;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   cy;
    logic [PIXEL_W-1:0]   pixel;
  } beat_t;

endpackage

/* sv/nns_div.sv */
`timescale 1ns / 1ps
module nns_div (
  input  logic                      clk,
  input  logic [nns_pkg::DVD_W-1:0] dividend,
  input  logic [nns_pkg::FACT_W-1:0] divisor,
  output logic [nns_pkg::DVD_W-1:0] quotient
);
  import nns_pkg::*;

  // restoring division, one quotient bit per stage
  logic [FACT_W:0]   rem [DVD_W];
  logic [DVD_W-1:0]  quo [DVD_W];
  logic [DVD_W-1:0]  dvd [DVD_W];

  genvar i;
  generate
    for (i = 0; i < DVD_W; i++) begin : g_stage
      logic [FACT_W:0]  rem_in;
      logic [DVD_W-1:0] quo_in;
      logic [DVD_W-1:0] dvd_in;
      logic [FACT_W:0]  trial;
      if (i == 0) begin : g_first
        assign rem_in = '0;
        assign quo_in = '0;
        assign dvd_in = dividend;
      end else begin : g_next
        assign rem_in = rem[i-1];
        assign quo_in = quo[i-1];
        assign dvd_in = dvd[i-1];
      end
      assign trial = {rem_in[FACT_W-1:0], dvd_in[DVD_W-1]};
      always_ff @(posedge clk) begin
        if (trial >= {1'b0, divisor}) begin
          rem[i] <= trial - {1'b0, divisor};
          quo[i] <= {quo_in[DVD_W-2:0], 1'b1};
        end else begin
          rem[i] <= trial;
          quo[i] <= {quo_in[DVD_W-2:0], 1'b0};
        end
        dvd[i] <= {dvd_in[DVD_W-2:0], 1'b0};
      end
    end
  endgenerate

  assign quotient = quo[DVD_W-1];

endmodule

/* sv/nearest_neighbor_scaler_core.sv */
`timescale 1ns / 1ps
// Nearest-neighbor scaler over a stored source image. One beat (pixel write or scaled
// pixel read) is taken every clock and busy never rises; every beat gives one result
// on done after pipelined source-coordinate division, one clamp stage and one pixel
// memory stage. Writes and reads pass the memory in arrival order, so a read sees
// every earlier write. Results cannot be held off.
// Set the registers only while no beat is in flight.
module nearest_neighbor_scaler_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation,
  input  logic [nns_pkg::COORD_W-1:0]  coord_x,
  input  logic [nns_pkg::COORD_W-1:0]  coord_y,
  input  logic [nns_pkg::PIXEL_W-1:0]  pixel_in,
  output logic                         done,
  output logic [nns_pkg::PIXEL_W-1:0]  pixel_out,
  output logic                         status,
  output logic [nns_pkg::COORD_W-1:0]  scaled_width,
  output logic [nns_pkg::COORD_W-1:0]  scaled_height,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nns_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import nns_pkg::*;

  localparam int WORDS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [SIZE_W-1:0] source_width, source_height;
  logic [FACT_W-1:0] scale_factor;
  reg_idx_t          widx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SIZE_W'(256);
      source_height <= SIZE_W'(256);
      scale_factor  <= FACT_W'(256);
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_WIDTH:  source_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: source_height <= pwdata[SIZE_W-1:0];
        REG_FACTOR: scale_factor  <= pwdata[FACT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_WIDTH:  prdata = 32'(source_width);
      REG_HEIGHT: prdata = 32'(source_height);
      REG_FACTOR: prdata = 32'(scale_factor);
      default:    prdata = '0;
    endcase
  end

  // effective and scaled sizes, refreshed every cycle from the registers
  logic [SIZE_W-1:0]       eff_w, eff_h;
  logic [COORD_W-1:0]      sw, sh;
  logic [SIZE_W+FACT_W-1:0] prod_w, prod_h;

  assign prod_w = scale_factor * eff_w;
  assign prod_h = scale_factor * eff_h;

  always_ff @(posedge clk) begin
    eff_w <= (32'(source_width) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : source_width;
    eff_h <= (32'(source_height) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : source_height;
    sw <= (prod_w[SIZE_W+FACT_W-1:FRAC_W] > 17'hFFFF) ? 16'hFFFF
          : prod_w[COORD_W+FRAC_W-1:FRAC_W];
    sh <= (prod_h[SIZE_W+FACT_W-1:FRAC_W] > 17'hFFFF) ? 16'hFFFF
          : prod_h[COORD_W+FRAC_W-1:FRAC_W];
  end

  // entry beat; the range check waits for the clamp stage, where the sizes have settled
  beat_t in_beat;
  always_comb begin
    in_beat.valid = start;
    in_beat.op    = operation;
    in_beat.bad   = 1'b0;
    in_beat.cx    = coord_x;
    in_beat.cy    = coord_y;
    in_beat.pixel = pixel_in;
  end

  logic [DVD_W-1:0] qx, qy;

  nns_div u_div_x (
    .clk      (clk),
    .dividend ({coord_x, {FRAC_W{1'b0}}}),
    .divisor  (scale_factor),
    .quotient (qx)
  );

  nns_div u_div_y (
    .clk      (clk),
    .dividend ({coord_y, {FRAC_W{1'b0}}}),
    .divisor  (scale_factor),
    .quotient (qy)
  );

  beat_t line [DVD_W];

  always_ff @(posedge clk) begin
    for (int k = 0; k < DVD_W; k++) begin
      if (rst)         line[k].valid <= 1'b0;
      else if (k == 0) line[k] <= in_beat;
      else             line[k] <= line[k-1];
    end
  end

  // clamp stage
  beat_t             cb, cb_next;
  logic [SIZE_W-1:0] sx, sy;
  logic [SIZE_W-1:0] lim_w, lim_h;

  assign lim_w = eff_w - 1'b1;
  assign lim_h = eff_h - 1'b1;

  always_comb begin
    cb_next = line[DVD_W-1];
    if (line[DVD_W-1].op == OP_WRITE)
      cb_next.bad = !((line[DVD_W-1].cx < COORD_W'(eff_w)) &&
                      (line[DVD_W-1].cy < COORD_W'(eff_h)));
    else
      cb_next.bad = !((line[DVD_W-1].cx < sw) && (line[DVD_W-1].cy < sh));
  end

  always_ff @(posedge clk) begin
    if (rst) cb.valid <= 1'b0;
    else     cb <= cb_next;
    if (line[DVD_W-1].op == OP_WRITE) begin
      sx <= line[DVD_W-1].cx[SIZE_W-1:0];
      sy <= line[DVD_W-1].cy[SIZE_W-1:0];
    end else begin
      sx <= (qx > DVD_W'(lim_w)) ? lim_w : qx[SIZE_W-1:0];
      sy <= (qy > DVD_W'(lim_h)) ? lim_h : qy[SIZE_W-1:0];
    end
  end

  // pixel memory stage
  logic [PIXEL_W-1:0] mem [WORDS];
  logic [31:0]        addr_full;
  logic [AW-1:0]      addr;
  logic [PIXEL_W-1:0] rd_data;
  beat_t              mb;

  assign addr_full = 32'(sy) * 32'(MAX_WIDTH) + 32'(sx);
  assign addr      = addr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (cb.valid && cb.op == OP_WRITE && !cb.bad)
      mem[addr] <= cb.pixel;
    rd_data <= mem[addr];
    if (rst) mb.valid <= 1'b0;
    else     mb <= cb;
  end

  assign done          = mb.valid;
  assign status        = mb.bad;
  assign pixel_out     = (mb.op == OP_READ && !mb.bad) ? rd_data : '0;
  assign scaled_width  = sw;
  assign scaled_height = sh;

endmodule
